[src/rpq_pkg.sv]
// Shared types and constants for the record priority queue.
// No dependencies; imported by every other file in src.
`default_nettype none

package rpq_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 32;
  localparam int unsigned PRIO_W           = 8;
  localparam int unsigned NUM_LEVELS       = 1 << PRIO_W;
  localparam int unsigned FREE_W           = 6;

  typedef struct packed {
    logic [15:0]       plate;
    logic [7:0]        origin;
    logic [7:0]        destination;
    logic [PRIO_W-1:0] prio;
  } rec_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  // Memory strobes from the controller to the store.
  typedef struct packed {
    logic rec_we;
    logic rec_re;
    logic next_we;
    logic next_re;
    logic ht_we;
    logic ht_re;
  } store_ctrl_t;

  // Occupancy map update: mark a level occupied or empty.
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [PRIO_W-1:0] level;
  } level_upd_t;

endpackage

`default_nettype wire

[src/rpq_store.sv]
// Record, link and per-level head/tail memories of the record priority queue.
// Depends on rpq_pkg. All reads are registered.
`default_nettype none

module rpq_store #(
  parameter int unsigned CAPACITY = rpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk_i,
  input  rpq_pkg::store_ctrl_t             ctrl_i,
  input  logic [$clog2(CAPACITY)-1:0]      rec_waddr_i,
  input  rpq_pkg::rec_t                    rec_wdata_i,
  input  logic [$clog2(CAPACITY)-1:0]      rec_raddr_i,
  output rpq_pkg::rec_t                    rec_rdata_o,
  input  logic [$clog2(CAPACITY)-1:0]      next_waddr_i,
  input  logic [$clog2(CAPACITY)-1:0]      next_wdata_i,
  input  logic [$clog2(CAPACITY)-1:0]      next_raddr_i,
  output logic [$clog2(CAPACITY)-1:0]      next_rdata_o,
  input  logic [rpq_pkg::PRIO_W-1:0]       ht_waddr_i,
  input  logic [$clog2(CAPACITY)-1:0]      ht_whead_i,
  input  logic [$clog2(CAPACITY)-1:0]      ht_wtail_i,
  input  logic [rpq_pkg::PRIO_W-1:0]       ht_raddr_i,
  output logic [$clog2(CAPACITY)-1:0]      ht_rhead_o,
  output logic [$clog2(CAPACITY)-1:0]      ht_rtail_o
);
  import rpq_pkg::*;

  localparam int unsigned PTR_W = $clog2(CAPACITY);

  rec_t             rec_mem  [CAPACITY];
  logic [PTR_W-1:0] next_mem [CAPACITY];
  logic [2*PTR_W-1:0] ht_mem [NUM_LEVELS];

  // record payloads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rec_we) begin
      rec_mem[rec_waddr_i] <= rec_wdata_i;
    end
    if (ctrl_i.rec_re) begin
      rec_rdata_o <= rec_mem[rec_raddr_i];
    end
  end

  // successor links, shared by the level lists and the free list
  always_ff @(posedge clk_i) begin
    if (ctrl_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    if (ctrl_i.next_re) begin
      next_rdata_o <= next_mem[next_raddr_i];
    end
  end

  // head and tail slot of each priority level
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ht_we) begin
      ht_mem[ht_waddr_i] <= {ht_whead_i, ht_wtail_i};
    end
    if (ctrl_i.ht_re) begin
      {ht_rhead_o, ht_rtail_o} <= ht_mem[ht_raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/rpq_level_map.sv]
// Occupancy map over all priority levels with a two-step highest-level search.
// Depends on rpq_pkg. Group index is registered, level index is derived combinationally from it.
`default_nettype none

module rpq_level_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rpq_pkg::level_upd_t         upd_i,
  input  logic [rpq_pkg::PRIO_W-1:0]  query_i,
  output logic                        hit_o,
  output logic                        any_o,
  output logic [rpq_pkg::PRIO_W-1:0]  level_o
);
  import rpq_pkg::*;

  localparam int unsigned SUB_W  = PRIO_W / 2;
  localparam int unsigned GRP_W  = PRIO_W - SUB_W;
  localparam int unsigned GRP_N  = 1 << GRP_W;
  localparam int unsigned SUB_N  = 1 << SUB_W;

  logic [NUM_LEVELS-1:0] map_q;
  logic [GRP_W-1:0]      grp_q;
  logic [GRP_N-1:0]      grp_any;
  logic [GRP_W-1:0]      grp_top;
  logic [SUB_N-1:0]      sub_bits;
  logic [SUB_W-1:0]      sub_top;

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |map_q[g*SUB_N +: SUB_N];
    end
  end

  always_comb begin
    grp_top = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (grp_any[g]) begin
        grp_top = GRP_W'(g);
      end
    end
  end

  assign sub_bits = map_q[grp_q*SUB_N +: SUB_N];

  always_comb begin
    sub_top = '0;
    for (int s = 0; s < SUB_N; s++) begin
      if (sub_bits[s]) begin
        sub_top = SUB_W'(s);
      end
    end
  end

  assign level_o = {grp_q, sub_top};
  assign any_o   = |grp_any;
  assign hit_o   = map_q[query_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      grp_q <= '0;
    end else begin
      grp_q <= grp_top;
      if (upd_i.set) begin
        map_q[upd_i.level] <= 1'b1;
      end else if (upd_i.clr) begin
        map_q[upd_i.level] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/record_priority_queue.sv]
// Top level of the record priority queue: controller, result register, assertions.
// Depends on rpq_pkg, rpq_store and rpq_level_map.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  request  | req_valid_i / req_ready_o  | op_i plate_i origin_i destination_i priority_req_i
//  result   | res_valid_o / res_ready_i  | out_plate_o .. out_priority_o out_valid_o
//           |                            | full_drop_o empty_miss_o free_slots_o
//
// An insert runs S_IDLE then S_INS, a dropped/missed word S_IDLE then S_MISS, an extract
// S_IDLE, S_XFIND, S_XHEAD and S_XDONE; the result register loads in the last of them.
// Extract steps: group search, level search with head/tail read, record read, write-back.
// Reset is asynchronous; it empties the occupancy map and the counters, memories are
// left as they are (only linked, occupied entries are ever used).
// A result waits in its register; the next word is taken meanwhile, write-back waits for it.
`default_nettype none

module record_priority_queue #(
  parameter int unsigned CAPACITY = rpq_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        op_i,
  input  logic [15:0] plate_i,
  input  logic [7:0]  origin_i,
  input  logic [7:0]  destination_i,
  input  logic [7:0]  priority_req_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [15:0] out_plate_o,
  output logic [7:0]  out_origin_o,
  output logic [7:0]  out_destination_o,
  output logic [7:0]  out_priority_o,
  output logic        out_valid_o,
  output logic        full_drop_o,
  output logic        empty_miss_o,
  output logic [rpq_pkg::FREE_W-1:0] free_slots_o
);
  import rpq_pkg::*;

  localparam int unsigned PTR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned DIFF_W = (CNT_W > FREE_W) ? CNT_W : FREE_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_XFIND,
    S_XHEAD,
    S_XDONE,
    S_MISS
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  rec_t             rec_q, rec_d;
  logic [PRIO_W-1:0] lvl_q, lvl_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [PTR_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] count_q, count_d;
  // high-water mark: slots below it have been handed out at least once
  logic [CNT_W-1:0] hwm_q, hwm_d;

  logic             res_valid_q, res_valid_d;
  rec_t             res_rec_q, res_rec_d;
  logic             res_hit_q, res_hit_d;
  logic             res_full_q, res_full_d;
  logic             res_empty_q, res_empty_d;
  logic [FREE_W-1:0] res_free_q, res_free_d;

  logic             out_free;
  logic             load_res;
  logic [CNT_W-1:0] res_count;
  logic [DIFF_W-1:0] free_wide;
  logic             use_free;
  logic [PTR_W-1:0] slot;

  // store interface
  store_ctrl_t      st_ctrl;
  logic [PTR_W-1:0] rec_waddr, rec_raddr;
  rec_t             rec_wdata, rec_rdata;
  logic [PTR_W-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
  logic [PRIO_W-1:0] ht_waddr, ht_raddr;
  logic [PTR_W-1:0] ht_whead, ht_wtail, ht_rhead, ht_rtail;

  // level map interface
  level_upd_t       map_upd;
  logic             map_hit;
  logic             map_any;
  logic [PRIO_W-1:0] map_level;

  rpq_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i        (clk_i),
    .ctrl_i       (st_ctrl),
    .rec_waddr_i  (rec_waddr),
    .rec_wdata_i  (rec_wdata),
    .rec_raddr_i  (rec_raddr),
    .rec_rdata_o  (rec_rdata),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .next_raddr_i (next_raddr),
    .next_rdata_o (next_rdata),
    .ht_waddr_i   (ht_waddr),
    .ht_whead_i   (ht_whead),
    .ht_wtail_i   (ht_wtail),
    .ht_raddr_i   (ht_raddr),
    .ht_rhead_o   (ht_rhead),
    .ht_rtail_o   (ht_rtail)
  );

  rpq_level_map u_level_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (map_upd),
    .query_i (rec_q.prio),
    .hit_o   (map_hit),
    .any_o   (map_any),
    .level_o (map_level)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign out_free    = !res_valid_q || res_ready_i;

  // Free slots come from the free list while it holds any (count below the
  // high-water mark), otherwise from the never-used region.
  assign use_free = (count_q != hwm_q);
  assign slot     = use_free ? free_head_q : hwm_q[PTR_W-1:0];

  assign free_wide = DIFF_W'(CAPACITY) - DIFF_W'(res_count);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rec_d       = rec_q;
    lvl_d       = lvl_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    count_d     = count_q;
    hwm_d       = hwm_q;

    st_ctrl    = '0;
    rec_waddr  = slot;
    rec_wdata  = rec_q;
    rec_raddr  = ht_rhead;
    next_waddr = head_q;
    next_wdata = free_head_q;
    next_raddr = free_head_q;
    ht_waddr   = lvl_q;
    ht_whead   = head_q;
    ht_wtail   = tail_q;
    ht_raddr   = priority_req_i;
    map_upd    = '0;

    load_res    = 1'b0;
    res_count   = count_q;
    res_rec_d   = '0;
    res_hit_d   = 1'b0;
    res_full_d  = 1'b0;
    res_empty_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = op_e'(op_i);
          rec_d = '{plate: plate_i, origin: origin_i, destination: destination_i,
                    prio: priority_req_i};
          lvl_d = priority_req_i;
          if (op_e'(op_i) == OP_INSERT) begin
            if (count_q == CAP_CNT) begin
              state_d = S_MISS;
            end else begin
              // fetch the level's head/tail and the free-list successor
              st_ctrl.ht_re   = 1'b1;
              ht_raddr        = priority_req_i;
              st_ctrl.next_re = 1'b1;
              next_raddr      = free_head_q;
              state_d         = S_INS;
            end
          end else begin
            state_d = (count_q == '0) ? S_MISS : S_XFIND;
          end
        end
      end

      S_INS: begin
        if (out_free) begin
          st_ctrl.rec_we = 1'b1;
          rec_waddr      = slot;
          rec_wdata      = rec_q;
          st_ctrl.ht_we  = 1'b1;
          ht_waddr       = lvl_q;
          ht_wtail       = slot;
          if (map_hit) begin
            // append behind the current tail
            ht_whead        = ht_rhead;
            st_ctrl.next_we = 1'b1;
            next_waddr      = ht_rtail;
            next_wdata      = slot;
          end else begin
            ht_whead      = slot;
            map_upd.set   = 1'b1;
            map_upd.level = lvl_q;
          end
          if (use_free) begin
            free_head_d = next_rdata;
          end else begin
            hwm_d = hwm_q + CNT_W'(1);
          end
          count_d   = count_q + CNT_W'(1);
          res_count = count_d;
          load_res  = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_XFIND: begin
        st_ctrl.ht_re = 1'b1;
        ht_raddr      = map_level;
        lvl_d         = map_level;
        state_d       = S_XHEAD;
      end

      S_XHEAD: begin
        head_d          = ht_rhead;
        tail_d          = ht_rtail;
        st_ctrl.rec_re  = 1'b1;
        rec_raddr       = ht_rhead;
        st_ctrl.next_re = 1'b1;
        next_raddr      = ht_rhead;
        state_d         = S_XDONE;
      end

      S_XDONE: begin
        if (out_free) begin
          if (head_q == tail_q) begin
            map_upd.clr   = 1'b1;
            map_upd.level = lvl_q;
          end else begin
            st_ctrl.ht_we = 1'b1;
            ht_waddr      = lvl_q;
            ht_whead      = next_rdata;
            ht_wtail      = tail_q;
          end
          // the removed slot goes on top of the free list
          st_ctrl.next_we = 1'b1;
          next_waddr      = head_q;
          next_wdata      = free_head_q;
          free_head_d     = head_q;
          count_d         = count_q - CNT_W'(1);
          res_count       = count_d;
          res_rec_d       = rec_rdata;
          res_hit_d       = 1'b1;
          load_res        = 1'b1;
          state_d         = S_IDLE;
        end
      end

      S_MISS: begin
        if (out_free) begin
          res_full_d  = (op_q == OP_INSERT);
          res_empty_d = (op_q == OP_EXTRACT);
          load_res    = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_free_d = free_wide[FREE_W-1:0];

    if (load_res) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      hwm_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      hwm_q       <= hwm_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    rec_q       <= rec_d;
    lvl_q       <= lvl_d;
    head_q      <= head_d;
    tail_q      <= tail_d;
    free_head_q <= free_head_d;
    if (load_res) begin
      res_rec_q   <= res_rec_d;
      res_hit_q   <= res_hit_d;
      res_full_q  <= res_full_d;
      res_empty_q <= res_empty_d;
      res_free_q  <= res_free_d;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign out_plate_o       = res_rec_q.plate;
  assign out_origin_o      = res_rec_q.origin;
  assign out_destination_o = res_rec_q.destination;
  assign out_priority_o    = res_rec_q.prio;
  assign out_valid_o       = res_hit_q;
  assign full_drop_o       = res_full_q;
  assign empty_miss_o      = res_empty_q;
  assign free_slots_o      = res_free_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("live record count above capacity");

  a_hwm_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hwm_q)
    else $error("more live records than slots ever handed out");

  a_find_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XFIND) |-> map_any)
    else $error("extract search on an empty occupancy map");

  a_count_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_res |=> (count_q == $past(count_q)))
    else $error("record count changed without a result");
`endif

endmodule

`default_nettype wire
